// File: hw/rtl/qpdl_pkg.sv
package qpdl_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QP_ENABLE   = 2'd1;

  localparam logic [7:0] LINE_LENGTH_RESET = 8'd79;
  localparam logic       QP_ENABLE_RESET   = 1'b1;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UF  = 8'h46;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_EQUAL  = 2'd1,
    PH_HEX    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] line_length;
    logic       qp_enable;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] high_nibble;
    logic [7:0] chars_in_line;
  } state_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       line_done;
    logic       body_done;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [7:0] cnt;
    logic       ldone;
  } count_t;

  typedef struct packed {
    logic       has;
    result_t    res;
    logic [7:0] cnt;
    logic       esc;
  } plain_t;

  function automatic hex_t hex_decode(logic [7:0] b, logic lower_ok);
    hex_t h;
    h.ok  = 1'b1;
    h.val = b[3:0];
    if (b >= CH_0 && b <= CH_9) begin
      h.val = b[3:0];
    end else if (b >= CH_UA && b <= CH_UF) begin
      h.val = 4'(b[3:0] + 4'd9);
    end else if (lower_ok && b >= CH_LA && b <= CH_LF_HEX) begin
      h.val = 4'(b[3:0] + 4'd9);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // A line ends when the count reaches the limit or wraps around.
  function automatic count_t line_count(logic [7:0] cnt, logic [7:0] len);
    count_t c;
    logic [7:0] inc;
    inc = 8'(cnt + 8'd1);
    if (inc >= len || inc == 8'd0) begin
      c.cnt   = 8'd0;
      c.ldone = 1'b1;
    end else begin
      c.cnt   = inc;
      c.ldone = 1'b0;
    end
    return c;
  endfunction

  function automatic result_t char_result(logic [7:0] ch, logic ldone);
    result_t r;
    r.out_char    = ch;
    r.char_valid  = 1'b1;
    r.line_done   = ldone;
    r.body_done   = 1'b0;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic plain_t plain_step(logic [7:0] b, logic qp_en,
                                        logic [7:0] cnt, logic [7:0] len);
    plain_t p;
    count_t c;
    c     = line_count(cnt, len);
    p.has = 1'b0;
    p.res = '0;
    p.cnt = cnt;
    p.esc = 1'b0;
    if (b == CH_CR) begin
      p.has = 1'b0;
    end else if (b == CH_LF) begin
      p.has           = 1'b1;
      p.res.line_done = 1'b1;
      p.cnt           = 8'd0;
    end else if (b == CH_EQ && qp_en) begin
      p.esc = 1'b1;
    end else begin
      p.has = 1'b1;
      p.res = char_result(b, c.ldone);
      p.cnt = c.cnt;
    end
    return p;
  endfunction

endpackage

// File: hw/rtl/qpdl_if.sv
interface qpdl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       message_end;

  modport source (output valid, output in_byte, output message_end, input ready);
  modport sink (input valid, input in_byte, input message_end, output ready);
endinterface

interface qpdl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       line_done;
  logic       body_done;
  logic       last_of_run;

  modport source (output valid, output out_char, output char_valid, output line_done,
                  output body_done, output last_of_run, input ready);
  modport sink (input valid, input out_char, input char_valid, input line_done,
                input body_done, input last_of_run, output ready);
endinterface

// File: hw/rtl/qp_decode_line_wrapper.sv
// Flow: an accepted transaction is registered, decoded combinationally while it is held, and
// its results are written into the result buffer, from which they are offered on dout.
// Throughput: one input transaction per cycle while the result buffer has room for two
// results; an input that yields two results is absorbed by the four-entry result buffer.
// Reset: synchronous, clears the decoder state and buffers, and loads line_length 79
// and qp_enable 1.
module qp_decode_line_wrapper (
  input  logic                              clk,
  input  logic                              rst,
  qpdl_in_if.sink                           din,
  qpdl_out_if.source                        dout,
  input  logic                              cfg_we,
  input  logic [qpdl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qpdl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  qpdl_pkg::cfg_t    cfg;
  qpdl_pkg::state_t  st;
  qpdl_pkg::result_t res0;
  qpdl_pkg::result_t res1;
  logic [1:0]        res_count;
  logic [1:0]        push_count;
  logic              space;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_end_q;
  logic              fire;

  assign fire       = in_valid_q & space;
  assign din.ready  = ~in_valid_q | fire;
  assign push_count = fire ? res_count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_length <= qpdl_pkg::LINE_LENGTH_RESET;
      cfg.qp_enable   <= qpdl_pkg::QP_ENABLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        qpdl_pkg::CFG_LINE_LENGTH: cfg.line_length <= cfg_wdata;
        qpdl_pkg::CFG_QP_ENABLE:   cfg.qp_enable   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (din.valid && din.ready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      in_byte_q <= din.in_byte;
      in_end_q  <= din.message_end;
    end
  end

  qpdl_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .in_byte     (in_byte_q),
    .message_end (in_end_q),
    .cfg         (cfg),
    .res_count   (res_count),
    .res0        (res0),
    .res1        (res1),
    .st          (st)
  );

  qpdl_result_buf u_result_buf (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .space      (space),
    .dout       (dout)
  );

`ifndef SYNTH
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !fire |=> in_valid_q && $stable(in_byte_q) && $stable(in_end_q))
    else $error("held input transaction changed before it was decoded");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && in_end_q |=> st.phase == qpdl_pkg::PH_NORMAL && st.chars_in_line == 8'd0
      && st.high_nibble == 4'd0)
    else $error("message end did not clear the decoder state");

  a_hex_after_equal: assert property (@(posedge clk) disable iff (rst)
    st.phase == qpdl_pkg::PH_HEX && $past(st.phase) != qpdl_pkg::PH_HEX
      |-> $past(st.phase) == qpdl_pkg::PH_EQUAL)
    else $error("hex escape entered without a preceding equals sign");
`endif

endmodule

// File: hw/rtl/qpdl_decode.sv
module qpdl_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  input  logic              message_end,
  input  qpdl_pkg::cfg_t    cfg,
  output logic [1:0]        res_count,
  output qpdl_pkg::result_t res0,
  output qpdl_pkg::result_t res1,
  output qpdl_pkg::state_t  st
);

  qpdl_pkg::state_t st_next;
  qpdl_pkg::hex_t   hex_upper;
  qpdl_pkg::hex_t   hex_any;
  qpdl_pkg::count_t esc_count;
  qpdl_pkg::plain_t plain_norm;
  qpdl_pkg::plain_t plain_after_eq;

  assign hex_upper  = qpdl_pkg::hex_decode(in_byte, 1'b0);
  assign hex_any    = qpdl_pkg::hex_decode(in_byte, 1'b1);
  assign esc_count  = qpdl_pkg::line_count(st.chars_in_line, cfg.line_length);
  assign plain_norm = qpdl_pkg::plain_step(in_byte, cfg.qp_enable, st.chars_in_line,
                                           cfg.line_length);
  assign plain_after_eq = qpdl_pkg::plain_step(in_byte, cfg.qp_enable, esc_count.cnt,
                                               cfg.line_length);

  always_comb begin
    st_next   = st;
    res_count = 2'd0;
    res0      = '0;
    res1      = '0;
    if (message_end) begin
      st_next.phase         = qpdl_pkg::PH_NORMAL;
      st_next.high_nibble   = 4'd0;
      st_next.chars_in_line = 8'd0;
      res0.line_done        = 1'b1;
      res0.body_done        = 1'b1;
      res_count             = 2'd1;
    end else begin
      case (st.phase)
        qpdl_pkg::PH_EQUAL: begin
          st_next.phase = qpdl_pkg::PH_NORMAL;
          if (in_byte == qpdl_pkg::CH_CR || in_byte == qpdl_pkg::CH_LF) begin
            res_count = 2'd0;
          end else if (hex_upper.ok) begin
            st_next.high_nibble = hex_upper.val;
            st_next.phase       = qpdl_pkg::PH_HEX;
          end else begin
            res0      = qpdl_pkg::char_result(qpdl_pkg::CH_EQ, esc_count.ldone);
            res_count = 2'd1;
            if (plain_after_eq.has) begin
              res1      = plain_after_eq.res;
              res_count = 2'd2;
            end
            st_next.chars_in_line = plain_after_eq.cnt;
            if (plain_after_eq.esc) begin
              st_next.phase = qpdl_pkg::PH_EQUAL;
            end
          end
        end
        qpdl_pkg::PH_HEX: begin
          st_next.phase = qpdl_pkg::PH_NORMAL;
          if (hex_any.ok) begin
            res0 = qpdl_pkg::char_result({st.high_nibble, hex_any.val}, esc_count.ldone);
          end else begin
            res0 = qpdl_pkg::char_result({4'd0, st.high_nibble}, esc_count.ldone);
          end
          st_next.chars_in_line = esc_count.cnt;
          res_count             = 2'd1;
        end
        default: begin
          st_next.phase = qpdl_pkg::PH_NORMAL;
          if (plain_norm.has) begin
            res0      = plain_norm.res;
            res_count = 2'd1;
          end
          st_next.chars_in_line = plain_norm.cnt;
          if (plain_norm.esc) begin
            st_next.phase = qpdl_pkg::PH_EQUAL;
          end
        end
      endcase
    end
    if (res_count == 2'd2) begin
      res1.last_of_run = 1'b1;
    end else if (res_count == 2'd1) begin
      res0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= qpdl_pkg::PH_NORMAL;
      st.high_nibble   <= 4'd0;
      st.chars_in_line <= 8'd0;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

// File: hw/rtl/qpdl_result_buf.sv
module qpdl_result_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  qpdl_pkg::result_t push0,
  input  qpdl_pkg::result_t push1,
  output logic              space,
  qpdl_out_if.source        dout
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  qpdl_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [PTR_W-1:0]  wr_ptr_plus;
  logic              pop;

  assign wr_ptr_plus = PTR_W'(wr_ptr + 1'b1);
  assign pop         = dout.valid & dout.ready;
  assign space       = count <= CNT_W'(DEPTH - 2);

  assign dout.valid       = count != '0;
  assign dout.out_char    = mem[rd_ptr].out_char;
  assign dout.char_valid  = mem[rd_ptr].char_valid;
  assign dout.line_done   = mem[rd_ptr].line_done;
  assign dout.body_done   = mem[rd_ptr].body_done;
  assign dout.last_of_run = mem[rd_ptr].last_of_run;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_plus] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + push_count);
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      count <= CNT_W'(count + CNT_W'(push_count) - CNT_W'(pop));
    end
  end

endmodule
